FILE: hw/rtl/avrtp_pkg.sv
`timescale 1ns / 1ps
package avrtp_pkg;

  localparam int UNIT_BYTES    = 65536;
  localparam int SEQ_HDR_BYTES = 512;
  localparam int PACKET_BYTES  = 2048;
  localparam int UNIT_CAP      = UNIT_BYTES + 8;
  localparam int OUT_CAP       = 2 + SEQ_HDR_BYTES + UNIT_CAP;

  localparam int PEND_AW = $clog2(UNIT_BYTES);
  localparam int UNIT_AW = $clog2(UNIT_CAP);
  localparam int OUT_AW  = $clog2(OUT_CAP);
  localparam int SEQ_AW  = $clog2(SEQ_HDR_BYTES);
  localparam int SEQ_CW  = $clog2(SEQ_HDR_BYTES + 1);
  localparam int CNT_W   = 17;
  localparam int PLEN_W  = 12;

  localparam logic [7:0] TD_HDR_BYTE  = 8'h12;
  localparam logic [7:0] TD_SIZE_BYTE = 8'h00;
  localparam logic [7:0] OBU_HAS_SIZE = 8'h02;
  localparam logic [3:0] OBU_SEQ_HDR  = 4'd1;
  localparam logic [3:0] OBU_TD       = 4'd2;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_LOSS   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef struct packed {
    action_t             act;
    logic [7:0]          data;
    logic                start;
    logic [PLEN_W-1:0]   plen;
    logic                lost;
  } item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             out_valid;
    logic             out_last;
    logic             packet_ok;
    logic             unit_ready;
    logic [CNT_W-1:0] unit_length;
  } res_t;

endpackage

FILE: hw/rtl/avrtp_front.sv
`timescale 1ns / 1ps
module avrtp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,
  output logic                q_valid,
  output avrtp_pkg::item_t    q_item,
  input  logic                q_pop
);

  avrtp_pkg::item_t slot [2];
  avrtp_pkg::item_t in_item;
  logic             wr_sel;
  logic             rd_sel;
  logic [1:0]       cnt;
  logic             push;
  logic [11:0]      raw_len;

  // decode the word and clamp the packet length into 1..PACKET_BYTES
  always_comb begin
    raw_len       = s_tdata[22:11];
    in_item.act   = avrtp_pkg::action_t'(s_tdata[1:0]);
    in_item.data  = s_tdata[9:2];
    in_item.start = s_tdata[10];
    in_item.lost  = s_tdata[23];
    if (raw_len == '0) begin
      in_item.plen = 12'd1;
    end else if (raw_len > 12'(avrtp_pkg::PACKET_BYTES)) begin
      in_item.plen = 12'(avrtp_pkg::PACKET_BYTES);
    end else begin
      in_item.plen = raw_len;
    end
  end

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slot[rd_sel];
  assign push     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (q_pop) begin
        rd_sel <= ~rd_sel;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: hw/rtl/avrtp_engine.sv
`timescale 1ns / 1ps
module avrtp_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  avrtp_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              m_valid,
  input  logic              m_ready,
  output avrtp_pkg::res_t   m_res
);

  localparam int CW = avrtp_pkg::CNT_W;

  typedef enum logic [2:0] {
    M_IDLE, M_NEXT, M_LEB, M_DATA, M_HOLD
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_B, S_EMIT,
    S_P_HDR_RQ, S_P_HDR, S_P_EXT_RQ, S_P_EXT, S_P_SIZE, S_P_LEB_RQ, S_P_LEB,
    S_P_TYPE, S_P_PUT_HDR, S_P_PUT_EXT, S_P_PUT_LEB, S_P_PAY_RQ, S_P_PAY, S_P_DONE,
    S_F_H1, S_F_SEQ_RQ, S_F_SEQ, S_F_UNIT_RQ, S_F_UNIT, S_RD_RQ, S_RD
  } state_t;

  // stores
  logic [7:0] pend_mem [avrtp_pkg::UNIT_BYTES];
  logic [7:0] unit_mem [avrtp_pkg::UNIT_CAP];
  logic [7:0] seq_mem  [2*avrtp_pkg::SEQ_HDR_BYTES];
  logic [7:0] out_mem  [avrtp_pkg::OUT_CAP];
  logic [7:0] pend_q, unit_q, seq_q, out_q;

  state_t state;
  mode_t  mode;
  logic [CW-1:0] pending_count, unit_count, output_pointer, output_length;
  logic [avrtp_pkg::SEQ_CW-1:0] seq_count;
  logic seq_bank;
  logic fragment_open, unit_has_seq, unit_damaged, orphan_first;
  logic [4:0]  agg_flags;
  logic [11:0] packet_pos, packet_total, element_remaining;
  logic [1:0]  element_index;
  logic [CW-1:0] leb_value;
  logic leb_big, leb_done;
  logic [3:0] leb_bytes;
  logic elem_skip, elem_last;

  // push and copy working registers
  logic [7:0] hdr_r, ext_r;
  logic [CW-1:0] p_start, p_len, lv, base, v_r, pay_i, jr, kr;
  logic lbig, is_seq;
  logic [3:0] li;
  logic [avrtp_pkg::PEND_AW-1:0] rd_ptr;
  avrtp_pkg::res_t hold_res;

  // comb
  avrtp_pkg::item_t it;
  logic [7:0] b;
  logic abort_hit, fo1, z_bit, n_bit;
  logic [1:0] w;
  logic y;
  logic [17:0] lm_a, lm_p;
  logic [CW-1:0] unit_off;
  logic last_idx, b_next, b_begin, b_leb_start, b_fail, fail_len, over, skip, end_pkt;
  logic end_fail, dmg_b, b_big, last_calc, b_elem_last;
  logic [CW-1:0] b_elen;
  logic [11:0] avail;
  logic [18:0] sum;
  mode_t mode_b;
  logic [1:0] idx_n;
  logic [11:0] rem_n;
  logic [CW-1:0] vn;
  logic u_we, u_do;
  logic [7:0] u_wd;
  logic o_we;
  logic [7:0] o_wd;
  logic [CW-1:0] o_wa;
  logic em, out_free;
  avrtp_pkg::res_t em_res;
  logic dmg_f, fin_ok;
  logic [2:0] hl;

  function automatic logic [17:0] leb_merge(input logic [16:0] acc, input logic big,
                                            input logic [3:0] idx, input logic [7:0] d);
    logic [16:0] a;
    logic g;
    a = acc;
    g = big;
    case (idx)
      4'd0: a = acc | {10'd0, d[6:0]};
      4'd1: a = acc | {3'd0, d[6:0], 7'd0};
      4'd2: begin
        a = acc | {d[2:0], 14'd0};
        g = big | (|d[6:3]);
      end
      default: g = big | (|d[6:0]);
    endcase
    return {g, a};
  endfunction

  assign it        = q_item;
  assign b         = it.data;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign abort_hit = (packet_pos < packet_total);
  assign z_bit     = b[7];
  assign n_bit     = b[3];
  assign fo1       = fragment_open && !abort_hit && !it.lost && !n_bit;
  assign w         = agg_flags[2:1];
  assign y         = agg_flags[3];
  assign lm_a      = leb_merge(leb_value, leb_big, leb_bytes, b);
  assign lm_p      = leb_merge(lv, lbig, li, pend_q);
  assign unit_off  = unit_count - base;
  assign out_free  = !m_valid || m_ready;
  assign hl        = hdr_r[2] ? 3'd2 : 3'd1;

  // element bookkeeping after the byte has been taken
  always_comb begin
    last_idx    = (w != 2'd0) && (element_index == w - 2'd1);
    b_next      = (mode == M_NEXT) && (packet_pos < packet_total);
    b_begin     = leb_done || (b_next && last_idx);
    b_leb_start = b_next && !last_idx;
    avail       = packet_total - packet_pos;
    b_elen      = leb_done ? leb_value : CW'(avail);
    b_big       = leb_done && leb_big;
    skip        = (element_index == 2'd0) && orphan_first;
    fail_len    = (b_elen == '0) || b_big || (b_elen > CW'(avail));
    sum         = 19'(unit_count) + 19'(pending_count) + 19'(b_elen);
    over        = !skip && (sum > 19'(avrtp_pkg::UNIT_BYTES));
    b_fail      = b_begin && (fail_len || over);
    last_calc   = (CW'(packet_pos) + b_elen) == CW'(packet_total);
    b_elem_last = (w != 2'd0) ? last_idx : last_calc;
    if (b_begin) begin
      mode_b = b_fail ? M_HOLD : M_DATA;
    end else if (b_leb_start) begin
      mode_b = M_LEB;
    end else begin
      mode_b = mode;
    end
    end_pkt  = (packet_pos == packet_total);
    end_fail = end_pkt && ((mode_b == M_LEB) ||
               ((mode_b != M_HOLD) && (w != 2'd0) && (element_index < w)));
    dmg_b    = unit_damaged || b_fail || end_fail;
    idx_n    = (element_index == 2'd3) ? 2'd3 : element_index + 2'd1;
    rem_n    = element_remaining - 12'd1;
    fin_ok   = 1'b0;
    dmg_f    = unit_damaged || abort_hit || fragment_open;
    fin_ok   = !dmg_f && (unit_count != '0) && (seq_count != '0);
    vn       = v_r >> 7;
  end

  // unit and output write ports, result source
  always_comb begin
    u_we   = 1'b0;
    u_wd   = pend_q;
    o_we   = 1'b0;
    o_wd   = TD_OR_ZERO();
    o_wa   = kr;
    em     = 1'b0;
    em_res = '0;
    unique case (state)
      S_P_PUT_HDR: begin
        u_we = 1'b1;
        u_wd = hdr_r | avrtp_pkg::OBU_HAS_SIZE;
      end
      S_P_PUT_EXT: begin
        u_we = 1'b1;
        u_wd = ext_r;
      end
      S_P_PUT_LEB: begin
        u_we = 1'b1;
        u_wd = {(vn != '0), v_r[6:0]};
      end
      S_P_PAY: u_we = 1'b1;
      S_IDLE: begin
        if (q_valid) begin
          case (it.act)
            avrtp_pkg::ACT_BYTE: em = !it.start && !abort_hit;
            avrtp_pkg::ACT_LOSS: em = 1'b1;
            avrtp_pkg::ACT_FINISH: begin
              if (fin_ok) begin
                o_we = 1'b1;
                o_wa = '0;
                o_wd = avrtp_pkg::TD_HDR_BYTE;
              end else begin
                em = 1'b1;
              end
            end
            default: em = !(output_pointer < output_length);
          endcase
        end
      end
      S_B: begin
        em               = 1'b1;
        em_res.packet_ok = end_pkt && !dmg_b;
      end
      S_F_H1: begin
        o_we = 1'b1;
        o_wd = avrtp_pkg::TD_SIZE_BYTE;
      end
      S_F_SEQ: begin
        o_we = 1'b1;
        o_wd = seq_q;
      end
      S_F_UNIT: begin
        o_we = 1'b1;
        o_wd = unit_q;
        if (jr + CW'(1) == unit_count) begin
          em                 = 1'b1;
          em_res.unit_ready  = 1'b1;
          em_res.unit_length = kr + CW'(1);
        end
      end
      S_RD: begin
        em               = 1'b1;
        em_res.out_byte  = out_q;
        em_res.out_valid = 1'b1;
        em_res.out_last  = (output_pointer + CW'(1) == output_length);
      end
      default: ;
    endcase
    u_do = u_we && (unit_count < CW'(avrtp_pkg::UNIT_CAP));
  end

  function automatic logic [7:0] TD_OR_ZERO();
    return avrtp_pkg::TD_SIZE_BYTE;
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && it.act == avrtp_pkg::ACT_BYTE && !it.start &&
        abort_hit && mode == M_DATA && !elem_skip &&
        pending_count < CW'(avrtp_pkg::UNIT_BYTES)) begin
      pend_mem[pending_count[avrtp_pkg::PEND_AW-1:0]] <= b;
    end
    pend_q <= pend_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (u_do) begin
      unit_mem[unit_count[avrtp_pkg::UNIT_AW-1:0]] <= u_wd;
    end
    unit_q <= unit_mem[jr[avrtp_pkg::UNIT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (u_do && is_seq && unit_off < CW'(avrtp_pkg::SEQ_HDR_BYTES)) begin
      seq_mem[{~seq_bank, unit_off[avrtp_pkg::SEQ_AW-1:0]}] <= u_wd;
    end
    seq_q <= seq_mem[{seq_bank, jr[avrtp_pkg::SEQ_AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      out_mem[o_wa[avrtp_pkg::OUT_AW-1:0]] <= o_wd;
    end
    out_q <= out_mem[output_pointer[avrtp_pkg::OUT_AW-1:0]];
  end

  // payload-only registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_P_HDR: begin
        hdr_r   <= pend_q;
        p_start <= CW'(pend_q[2] ? 2 : 1);
        p_len   <= pending_count - CW'(pend_q[2] ? 2 : 1);
      end
      S_P_EXT: ext_r <= pend_q;
      S_P_SIZE: begin
        lv   <= '0;
        lbig <= 1'b0;
        li   <= '0;
      end
      S_P_LEB: begin
        lv      <= lm_p[16:0];
        lbig    <= lm_p[17];
        li      <= li + 4'd1;
        p_start <= p_start + CW'(1);
        if (!pend_q[7] && !lm_p[17] && lm_p[16:0] < p_len - CW'(1)) begin
          p_len <= lm_p[16:0];
        end else begin
          p_len <= p_len - CW'(1);
        end
      end
      S_P_TYPE: begin
        base   <= unit_count;
        v_r    <= p_len;
        pay_i  <= '0;
      end
      S_P_PUT_LEB: v_r <= vn;
      S_P_PAY: pay_i <= pay_i + CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= M_IDLE;
      pending_count  <= '0;
      unit_count     <= '0;
      seq_count      <= '0;
      seq_bank       <= 1'b0;
      output_pointer <= '0;
      output_length  <= '0;
      fragment_open  <= 1'b0;
      unit_has_seq   <= 1'b0;
      unit_damaged   <= 1'b0;
      orphan_first   <= 1'b0;
      agg_flags      <= '0;
      packet_pos     <= '0;
      packet_total   <= '0;
      element_index  <= '0;
      element_remaining <= '0;
      leb_value      <= '0;
      leb_big        <= 1'b0;
      leb_bytes      <= '0;
      leb_done       <= 1'b0;
      elem_skip      <= 1'b0;
      elem_last      <= 1'b0;
      is_seq         <= 1'b0;
      rd_ptr         <= '0;
      jr             <= '0;
      kr             <= '0;
      m_valid        <= 1'b0;
      m_res          <= '0;
      hold_res       <= '0;
    end else begin
      if (u_do) begin
        unit_count <= unit_count + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (it.act)
              avrtp_pkg::ACT_BYTE: begin
                leb_done <= 1'b0;
                if (it.start) begin
                  packet_total  <= it.plen;
                  packet_pos    <= 12'd1;
                  agg_flags     <= b[7:3];
                  orphan_first  <= z_bit && !fo1;
                  unit_damaged  <= unit_damaged || abort_hit || it.lost || !fo1 || !z_bit;
                  if (!(fo1 && z_bit) && (abort_hit || it.lost || n_bit || fo1 || z_bit)) begin
                    pending_count <= '0;
                  end
                  if (!(abort_hit || it.lost || fo1 || z_bit)) begin
                    unit_damaged <= unit_damaged;
                  end
                  fragment_open <= fo1 && z_bit;
                  element_index <= '0;
                  mode          <= M_NEXT;
                  state         <= S_B;
                end else if (abort_hit) begin
                  packet_pos <= packet_pos + 12'd1;
                  state      <= S_B;
                  if (mode == M_LEB) begin
                    leb_value <= lm_a[16:0];
                    leb_big   <= lm_a[17];
                    leb_bytes <= leb_bytes + 4'd1;
                    leb_done  <= !b[7];
                    if (b[7] && leb_bytes == 4'd7) begin
                      unit_damaged  <= 1'b1;
                      pending_count <= '0;
                      fragment_open <= 1'b0;
                      mode          <= M_HOLD;
                    end
                  end else if (mode == M_DATA) begin
                    if (!elem_skip && pending_count < CW'(avrtp_pkg::UNIT_BYTES)) begin
                      pending_count <= pending_count + CW'(1);
                    end
                    element_remaining <= rem_n;
                    if (rem_n == '0) begin
                      element_index <= idx_n;
                      mode <= ((w != 2'd0) && (idx_n >= w)) ? M_HOLD : M_NEXT;
                      if (!elem_skip) begin
                        if (elem_last && y) begin
                          fragment_open <= 1'b1;
                        end else begin
                          rd_ptr <= '0;
                          state  <= S_P_HDR_RQ;
                        end
                      end
                    end
                  end
                end
              end
              avrtp_pkg::ACT_LOSS: begin
                if (abort_hit) begin
                  packet_pos <= packet_total;
                  mode       <= M_IDLE;
                end
                unit_damaged  <= 1'b1;
                pending_count <= '0;
                fragment_open <= 1'b0;
              end
              avrtp_pkg::ACT_FINISH: begin
                if (abort_hit) begin
                  packet_pos <= packet_total;
                  mode       <= M_IDLE;
                end
                output_pointer <= '0;
                output_length  <= '0;
                if (fin_ok) begin
                  kr    <= CW'(1);
                  state <= S_F_H1;
                end else begin
                  pending_count <= '0;
                  unit_count    <= '0;
                  fragment_open <= 1'b0;
                  unit_has_seq  <= 1'b0;
                  unit_damaged  <= 1'b0;
                end
              end
              default: begin
                if (output_pointer < output_length) begin
                  state <= S_RD_RQ;
                end
              end
            endcase
          end
        end
        S_B: begin
          state <= S_IDLE;
          if (b_begin && !b_fail) begin
            element_remaining <= b_elen[11:0];
            elem_skip         <= skip;
            elem_last         <= b_elem_last;
          end
          if (b_leb_start) begin
            leb_value <= '0;
            leb_big   <= 1'b0;
            leb_bytes <= '0;
          end
          if (b_fail || end_fail) begin
            unit_damaged  <= 1'b1;
            pending_count <= '0;
            fragment_open <= 1'b0;
          end
          mode <= end_pkt ? M_IDLE : mode_b;
        end
        S_P_HDR_RQ: state <= S_P_HDR;
        S_P_HDR: begin
          is_seq <= 1'b0;
          if (pending_count == '0 || pending_count < CW'(pend_q[2] ? 2 : 1)) begin
            unit_damaged <= 1'b1;
            state        <= S_P_DONE;
          end else if (pend_q[2]) begin
            rd_ptr <= 16'd1;
            state  <= S_P_EXT_RQ;
          end else begin
            state <= S_P_SIZE;
          end
        end
        S_P_EXT_RQ: state <= S_P_EXT;
        S_P_EXT: state <= S_P_SIZE;
        S_P_SIZE: begin
          if (!hdr_r[1]) begin
            state <= S_P_TYPE;
          end else if (p_len == '0) begin
            unit_damaged <= 1'b1;
            state        <= S_P_DONE;
          end else begin
            rd_ptr <= p_start[avrtp_pkg::PEND_AW-1:0];
            state  <= S_P_LEB_RQ;
          end
        end
        S_P_LEB_RQ: state <= S_P_LEB;
        S_P_LEB: begin
          if (!pend_q[7]) begin
            state <= S_P_TYPE;
          end else if (li == 4'd7 || p_len == CW'(1)) begin
            unit_damaged <= 1'b1;
            state        <= S_P_DONE;
          end else begin
            rd_ptr <= 16'(p_start + CW'(1));
            state  <= S_P_LEB_RQ;
          end
        end
        S_P_TYPE: begin
          if (hdr_r[6:3] == avrtp_pkg::OBU_TD) begin
            state <= S_P_DONE;
          end else begin
            is_seq <= (hdr_r[6:3] == avrtp_pkg::OBU_SEQ_HDR);
            state  <= S_P_PUT_HDR;
          end
        end
        S_P_PUT_HDR: state <= hdr_r[2] ? S_P_PUT_EXT : S_P_PUT_LEB;
        S_P_PUT_EXT: state <= S_P_PUT_LEB;
        S_P_PUT_LEB: begin
          if (vn == '0) begin
            if (p_len == '0) begin
              state <= S_P_DONE;
            end else begin
              rd_ptr <= p_start[avrtp_pkg::PEND_AW-1:0];
              state  <= S_P_PAY_RQ;
            end
          end
        end
        S_P_PAY_RQ: state <= S_P_PAY;
        S_P_PAY: begin
          if (pay_i + CW'(1) == p_len) begin
            state <= S_P_DONE;
          end else begin
            rd_ptr <= 16'(p_start + pay_i + CW'(1));
            state  <= S_P_PAY_RQ;
          end
        end
        S_P_DONE: begin
          if (is_seq) begin
            unit_has_seq <= 1'b1;
            if (unit_off <= CW'(avrtp_pkg::SEQ_HDR_BYTES)) begin
              seq_bank  <= ~seq_bank;
              seq_count <= unit_off[avrtp_pkg::SEQ_CW-1:0];
            end
          end
          is_seq        <= 1'b0;
          pending_count <= '0;
          fragment_open <= 1'b0;
          state         <= S_B;
        end
        S_F_H1: begin
          kr    <= CW'(2);
          jr    <= '0;
          state <= unit_has_seq ? S_F_UNIT_RQ : S_F_SEQ_RQ;
        end
        S_F_SEQ_RQ: state <= S_F_SEQ;
        S_F_SEQ: begin
          kr <= kr + CW'(1);
          if (jr + CW'(1) == CW'(seq_count)) begin
            jr    <= '0;
            state <= S_F_UNIT_RQ;
          end else begin
            jr    <= jr + CW'(1);
            state <= S_F_SEQ_RQ;
          end
        end
        S_F_UNIT_RQ: state <= S_F_UNIT;
        S_F_UNIT: begin
          if (jr + CW'(1) == unit_count) begin
            output_length <= kr + CW'(1);
            pending_count <= '0;
            unit_count    <= '0;
            fragment_open <= 1'b0;
            unit_has_seq  <= 1'b0;
            unit_damaged  <= 1'b0;
            state         <= S_IDLE;
          end else begin
            kr    <= kr + CW'(1);
            jr    <= jr + CW'(1);
            state <= S_F_UNIT_RQ;
          end
        end
        S_RD_RQ: state <= S_RD;
        S_RD: begin
          output_pointer <= output_pointer + CW'(1);
          state          <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // output register; a result that cannot leave yet waits in hold_res
      if (state == S_EMIT) begin
        if (out_free) begin
          m_res   <= hold_res;
          m_valid <= 1'b1;
        end
      end else if (em && out_free) begin
        m_res   <= em_res;
        m_valid <= 1'b1;
      end else begin
        if (em) begin
          hold_res <= em_res;
          state    <= S_EMIT;
        end
        if (m_ready) begin
          m_valid <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/av1_rtp_depacketizer.sv
`timescale 1ns / 1ps
// AV1 RTP payload depacketizer. Payload bytes, loss marks, finish and read
// commands enter on s_*; every word gives exactly one result word on m_*.
// An input queue of two words sits ahead of the engine. The byte that closes
// an OBU starts the rewrite of the pending OBU into the unit buffer. A
// successful finish copies the assembled unit (prefix, cached sequence header
// when the unit holds none, unit) into the output bank. No clearing pass is
// needed after reset.
module av1_rtp_depacketizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], data_byte[9:2], packet_start[10], packet_length[22:11],
  // lost_before[23]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte[7:0], out_valid[8], packet_ok[9], unit_ready[10],
  // unit_length[27:11], zero[31:28]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  logic             q_valid;
  logic             q_pop;
  avrtp_pkg::item_t q_item;
  avrtp_pkg::res_t  res;

  avrtp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  avrtp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (res)
  );

  assign m_tdata = {4'd0, res.unit_length, res.unit_ready, res.packet_ok,
                    res.out_valid, res.out_byte};
  assign m_tlast = res.out_last;

endmodule

FILE: hw/rtl/avrtp_checker.sv
`timescale 1ns / 1ps
module avrtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // last marks only a real unit byte
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8])
    else $error("tlast without unit byte");

  // a refused or non-finish word reports zero length
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> m_tdata[27:11] == 17'd0)
    else $error("length without ready unit");

  // a read word never shares a result with a finish word or a packet verdict
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> !m_tdata[10] && !m_tdata[9])
    else $error("mixed result word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

endmodule

bind av1_rtp_depacketizer avrtp_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import avrtp_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int QUIET_WORDS    = 150;

  typedef enum {PS_IDLE, PS_NEXT, PS_LEB, PS_DATA, PS_HOLD} parse_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  av1_rtp_depacketizer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  // ---------------- depacketizer predictor state
  logic [7:0]  pend_mem [UNIT_BYTES];
  logic [7:0]  unit_mem [UNIT_CAP];
  logic [7:0]  seq_mem  [SEQ_HDR_BYTES];
  logic [7:0]  out_mem  [OUT_CAP];
  int unsigned pend_cnt, unit_cnt, seq_cnt, out_ptr, out_len;
  bit          frag_open, unit_has_seq, damaged;
  logic [4:0]  agg;
  int unsigned pkt_pos, pkt_total, elem_idx, elem_rem, leb_n;
  longint unsigned leb_val;
  parse_t      pmode;
  bit          elem_skip, elem_last, orphan;

  logic [23:0] word_q[$];
  res_t        expected_q[$];
  int          word_cnt, finish_cnt, ready_cnt, read_cnt, err_cnt;
  int          in_gap, out_gap, idle_cycles;

  function automatic int agg_w();
    return int'(agg[2:1]);
  endfunction

  task automatic drop_frag();
    damaged = 1;
    pend_cnt = 0;
    frag_open = 0;
  endtask

  task automatic fail_packet();
    drop_frag();
    pmode = PS_HOLD;
  endtask

  task automatic abort_packet();
    if (pkt_pos < pkt_total) begin
      drop_frag();
      pkt_pos = pkt_total;
      pmode = PS_IDLE;
    end
  endtask

  task automatic unit_put(input logic [7:0] b);
    if (unit_cnt < UNIT_CAP) begin
      unit_mem[unit_cnt] = b;
      unit_cnt++;
    end
  endtask

  // rewrite the pending obu to low-overhead form and append it to the unit, unless it is a temporal delimiter
  task automatic push_obu();
    int unsigned n, hl, st, plen, base, v, used;
    logic [7:0] hdr, b;
    logic [3:0] otype;
    longint unsigned sz;
    bit ok;
    n = pend_cnt;
    if (n < 1) return;
    hdr = pend_mem[0];
    otype = hdr[6:3];
    hl = hdr[2] ? 2 : 1;
    if (n < hl) begin
      damaged = 1;
      return;
    end
    st = hl;
    plen = n - hl;
    if (hdr[1]) begin
      sz = 0;
      used = 0;
      ok = 0;
      for (int i = 0; i < 8; i++) begin
        if (i >= plen) break;
        b = pend_mem[st + i];
        sz |= longint'(b & 8'h7f) << (7 * i);
        used = i + 1;
        if (!b[7]) begin
          ok = 1;
          break;
        end
      end
      if (!ok) begin
        damaged = 1;
        return;
      end
      st += used;
      plen -= used;
      if (sz < plen) plen = int'(sz);
    end
    if (otype == OBU_TD) return;
    base = unit_cnt;
    unit_put(hdr | OBU_HAS_SIZE);
    if (hdr[2]) unit_put(pend_mem[1]);
    v = plen;
    do begin
      b = 8'(v & 'h7f);
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      unit_put(b);
    end while (v != 0);
    for (int i = 0; i < plen; i++) unit_put(pend_mem[st + i]);
    if (otype == OBU_SEQ_HDR) begin
      if (unit_cnt - base <= SEQ_HDR_BYTES) begin
        for (int i = 0; i < unit_cnt - base; i++) seq_mem[i] = unit_mem[base + i];
        seq_cnt = unit_cnt - base;
      end
      unit_has_seq = 1;
    end
  endtask

  task automatic begin_element(input longint unsigned elen);
    int unsigned avail;
    bit skip;
    avail = pkt_total - pkt_pos;
    if (elen == 0 || elen > avail) begin
      fail_packet();
      return;
    end
    skip = (elem_idx == 0) && orphan;
    if (!skip && longint'(unit_cnt) + pend_cnt + elen > UNIT_BYTES) begin
      fail_packet();
      return;
    end
    elem_rem = int'(elen);
    elem_skip = skip;
    elem_last = (agg_w() != 0) ? (elem_idx == agg_w() - 1) : (pkt_pos + elen == pkt_total);
    pmode = PS_DATA;
  endtask

  task automatic next_element();
    if (agg_w() != 0 && elem_idx == agg_w() - 1) begin
      begin_element(pkt_total - pkt_pos);
    end else begin
      leb_val = 0;
      leb_n = 0;
      pmode = PS_LEB;
    end
  endtask

  task automatic finish_element();
    if (!elem_skip) begin
      if (elem_last && agg[3]) begin
        frag_open = 1;
      end else begin
        push_obu();
        pend_cnt = 0;
        frag_open = 0;
      end
    end
    if (elem_idx < 3) elem_idx++;
    if (agg_w() != 0 && elem_idx >= agg_w()) pmode = PS_HOLD;
    else pmode = PS_NEXT;
  endtask

  task automatic reset_unit();
    pend_cnt = 0;
    unit_cnt = 0;
    frag_open = 0;
    unit_has_seq = 0;
    damaged = 0;
  endtask

  task automatic depack_reset();
    seq_cnt = 0;
    out_ptr = 0;
    out_len = 0;
    reset_unit();
    agg = '0;
    pkt_pos = 0;
    pkt_total = 0;
    elem_idx = 0;
    elem_rem = 0;
    leb_val = 0;
    leb_n = 0;
    pmode = PS_IDLE;
    elem_skip = 0;
    elem_last = 0;
    orphan = 0;
  endtask

  task automatic depack_step(input item_t it, output res_t r);
    logic [7:0] b;
    int unsigned plen, k;
    bit leb_done;
    r = '0;
    b = it.data;
    leb_done = 0;
    case (it.act)
      ACT_BYTE: begin
        if (it.start) begin
          abort_packet();
          if (it.lost) drop_frag();
          plen = it.plen;
          if (plen == 0) plen = 1;
          if (plen > PACKET_BYTES) plen = PACKET_BYTES;
          pkt_total = plen;
          agg = b[7:3];
          if (b[3]) begin
            pend_cnt = 0;
            frag_open = 0;
          end
          orphan = b[7] && !frag_open;
          if (!b[7] && frag_open) drop_frag();
          if (orphan) begin
            damaged = 1;
            pend_cnt = 0;
          end
          elem_idx = 0;
          pmode = PS_NEXT;
          pkt_pos = 1;
        end else begin
          if (pkt_pos >= pkt_total) return;
          if (pmode == PS_LEB) begin
            leb_val |= longint'(b & 8'h7f) << (7 * leb_n);
            leb_n++;
            if (!b[7]) leb_done = 1;
            else if (leb_n >= 8) fail_packet();
          end else if (pmode == PS_DATA) begin
            if (!elem_skip && pend_cnt < UNIT_BYTES) begin
              pend_mem[pend_cnt] = b;
              pend_cnt++;
            end
            elem_rem--;
            if (elem_rem == 0) finish_element();
          end
          pkt_pos++;
        end
        if (leb_done) begin_element(leb_val);
        if (pmode == PS_NEXT && pkt_pos < pkt_total) next_element();
        if (pkt_pos == pkt_total) begin
          if (pmode == PS_LEB) fail_packet();
          else if (pmode != PS_HOLD && agg_w() != 0 && elem_idx < agg_w()) fail_packet();
          pmode = PS_IDLE;
          r.packet_ok = !damaged;
        end
      end
      ACT_LOSS: begin
        abort_packet();
        drop_frag();
      end
      ACT_FINISH: begin
        abort_packet();
        if (frag_open) damaged = 1;
        out_ptr = 0;
        out_len = 0;
        if (!damaged && unit_cnt != 0 && seq_cnt != 0) begin
          out_mem[0] = TD_HDR_BYTE;
          out_mem[1] = TD_SIZE_BYTE;
          k = 2;
          if (!unit_has_seq) begin
            for (int i = 0; i < seq_cnt; i++) out_mem[k + i] = seq_mem[i];
            k += seq_cnt;
          end
          for (int i = 0; i < unit_cnt; i++) out_mem[k + i] = unit_mem[i];
          k += unit_cnt;
          out_len = k;
          r.unit_ready = 1;
          r.unit_length = k[CNT_W-1:0];
        end
        reset_unit();
      end
      default: begin
        if (out_ptr < out_len) begin
          r.out_byte = out_mem[out_ptr];
          r.out_valid = 1;
          r.out_last = (out_ptr + 1 == out_len);
          out_ptr++;
        end
      end
    endcase
  endtask

  // ---------------- stimulus building
  task automatic add_word(input action_t act, input logic [7:0] data, input bit start,
                          input logic [11:0] plen, input bit lost);
    item_t it;
    res_t r;
    it.act = act;
    it.data = data;
    it.start = start;
    it.plen = plen;
    it.lost = lost;
    depack_step(it, r);
    word_q.push_back({lost, plen, start, data, act});
    expected_q.push_back(r);
    word_cnt++;
    if (act == ACT_FINISH) begin
      finish_cnt++;
      if (r.unit_ready) ready_cnt++;
    end
    if (act == ACT_READ) read_cnt++;
  endtask

  task automatic leb_append(ref logic [7:0] q[$], input int unsigned v);
    logic [7:0] b;
    do begin
      b = 8'(v & 'h7f);
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      q.push_back(b);
    end while (v != 0);
  endtask

  task automatic send_packet(ref logic [7:0] pkt[$], input bit lost, input int plen);
    for (int i = 0; i < pkt.size(); i++) begin
      if (i == 0) add_word(ACT_BYTE, pkt[i], 1'b1, 12'(plen), lost);
      else add_word(ACT_BYTE, pkt[i], 1'b0, 12'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_raw(input logic [7:0] a, input logic [7:0] b0, input logic [7:0] b1,
                          input int n);
    logic [7:0] pkt[$];
    pkt = {a, b0, b1};
    pkt = pkt[0:n-1];
    send_packet(pkt, 1'b0, n);
  endtask

  task automatic drain_reads();
    int n;
    n = out_len + $urandom_range(0, 2);
    if ($urandom_range(0, 15) == 0) n = $urandom_range(0, out_len);
    repeat (n) add_word(ACT_READ, 8'($urandom), 1'($urandom), 12'($urandom), 1'($urandom));
  endtask

  // a temporal unit of random obus, split into packets with random fragmentation and mishaps, then a finish and reads
  task automatic send_unit(input int n_obu, input int min_pay, input int max_pay,
                           input bit want_seq);
    logic [7:0] obu_bytes[$];
    int          obu_len[$];
    int          elen[$];
    logic [7:0]  pkt[$];
    logic [3:0]  otype;
    logic [7:0]  hdr;
    int          pay, sz, first, pos, oi, carry, nel, rem, part, w, mishap, plen;
    bit          z, y, nbit;
    pos = 0;
    for (int j = 0; j < n_obu; j++) begin
      first = obu_bytes.size();
      case ($urandom_range(0, 7))
        0: otype = OBU_TD;
        1: otype = OBU_SEQ_HDR;
        default: otype = 4'($urandom_range(3, 15));
      endcase
      if (j == 0 && want_seq) otype = OBU_SEQ_HDR;
      hdr = {($urandom_range(0, 7) == 0), otype, 1'($urandom), 1'($urandom), 1'($urandom)};
      pay = $urandom_range(min_pay, max_pay);
      obu_bytes.push_back(hdr);
      if (hdr[2]) obu_bytes.push_back(8'($urandom));
      if (hdr[1]) begin
        sz = pay;
        case ($urandom_range(0, 7))
          0, 1: sz = $urandom_range(0, pay);
          2: sz = pay + 5;
          default: ;
        endcase
        leb_append(obu_bytes, sz);
      end
      repeat (pay) obu_bytes.push_back(8'($urandom));
      obu_len.push_back(obu_bytes.size() - first);
    end
    oi = 0;
    carry = 0;
    nbit = ($urandom_range(0, 5) == 0);
    while (oi < obu_len.size() || carry > 0) begin
      pkt = {};
      elen = {};
      z = (carry > 0);
      y = 0;
      nel = $urandom_range(1, 3);
      for (int k = 0; k < nel; k++) begin
        if (carry == 0 && oi >= obu_len.size()) break;
        if (carry > 0) rem = carry;
        else begin
          rem = obu_len[oi];
          oi++;
        end
        if (k == nel - 1 && rem >= 2 && $urandom_range(0, 2) == 0) begin
          part = $urandom_range(1, rem - 1);
          carry = rem - part;
          y = 1;
        end else begin
          part = rem;
          carry = 0;
        end
        elen.push_back(part);
      end
      w = $urandom_range(0, 1) ? elen.size() : 0;
      pkt.push_back({z, y, 2'(w), nbit && !z, 3'($urandom)});
      nbit = 0;
      for (int j = 0; j < elen.size(); j++) begin
        if (!(w != 0 && j == w - 1)) leb_append(pkt, elen[j]);
        repeat (elen[j]) begin
          pkt.push_back(obu_bytes[pos]);
          pos++;
        end
      end
      mishap = $urandom_range(0, 39);
      plen = pkt.size();
      if (mishap == 0) begin
        add_word(ACT_LOSS, 8'($urandom), 1'($urandom), 12'($urandom), 1'($urandom));
        continue;
      end
      if (mishap == 2) plen = $urandom_range(1, pkt.size() + 3);
      if (mishap == 3 && pkt.size() > 1) pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
      send_packet(pkt, mishap == 1, plen);
    end
    add_word(ACT_FINISH, 8'($urandom), 1'($urandom), 12'($urandom), 1'($urandom));
    drain_reads();
  endtask

  // ---------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= word_q.pop_front();
        if (word_q.size() > QUIET_WORDS && $urandom_range(0, 9) == 0)
          in_gap <= $urandom_range(1, 9);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      m_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata[7:0] !== e.out_byte) begin
            $error("out_byte expected %h got %h", e.out_byte, m_tdata[7:0]);
            err_cnt++;
          end
          if (m_tdata[8] !== e.out_valid) begin
            $error("out_valid expected %b got %b", e.out_valid, m_tdata[8]);
            err_cnt++;
          end
          if (m_tlast !== e.out_last) begin
            $error("out_last expected %b got %b", e.out_last, m_tlast);
            err_cnt++;
          end
          if (m_tdata[9] !== e.packet_ok) begin
            $error("packet_ok expected %b got %b", e.packet_ok, m_tdata[9]);
            err_cnt++;
          end
          if (m_tdata[10] !== e.unit_ready) begin
            $error("unit_ready expected %b got %b", e.unit_ready, m_tdata[10]);
            err_cnt++;
          end
          if (m_tdata[27:11] !== e.unit_length) begin
            $error("unit_length expected %0d got %0d", e.unit_length, m_tdata[27:11]);
            err_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (word_q.size() > QUIET_WORDS && $urandom_range(0, 7) == 0)
          out_gap <= $urandom_range(1, 9);
      end
    end
  end

  // ---------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    depack_reset();
    // directed: read past end, stray byte, length zero, long truncated packet
    add_word(ACT_READ, 8'hff, 1'b1, 12'hfff, 1'b1);
    add_word(ACT_BYTE, 8'hff, 1'b0, 12'h000, 1'b0);
    add_word(ACT_BYTE, 8'h00, 1'b1, 12'h000, 1'b0);
    add_word(ACT_BYTE, 8'h10, 1'b1, 12'hfff, 1'b0);
    add_word(ACT_BYTE, 8'h55, 1'b0, 12'h800, 1'b1);
    add_word(ACT_FINISH, 8'h00, 1'b0, 12'h000, 1'b0);
    add_word(ACT_LOSS, 8'h00, 1'b0, 12'h000, 1'b0);
    // bad element: leb past packet end, zero length element, too few elements
    send_raw(8'h00, 8'h80, 8'h80, 3);
    send_raw(8'h00, 8'h00, 8'haa, 3);
    send_raw(8'h30, 8'h01, 8'h0a, 3);
    // orphan continuation
    send_raw(8'h90, 8'h30, 8'h01, 3);
    add_word(ACT_FINISH, 8'h00, 1'b0, 12'h000, 1'b0);
    add_word(ACT_READ, 8'h00, 1'b0, 12'h000, 1'b0);
    send_unit(2, 0, 6, 1'b1);
    send_unit(2, 0, 6, 1'b0);
    // sequence header too large for the cache
    send_unit(1, 590, 600, 1'b1);
    send_unit(1, 0, 4, 1'b0);
    while (word_cnt < 1500) begin
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 3))
          add_word(action_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                   12'($urandom), 1'($urandom));
      end else begin
        send_unit($urandom_range(1, 4), 0, ($urandom_range(0, 9) == 0) ? 60 : 12,
                  $urandom_range(0, 2) == 0);
      end
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (word_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d input words, %0d finishes (%0d units ready), %0d reads",
             word_cnt, finish_cnt, ready_cnt, read_cnt);
    if (err_cnt == 0 && expected_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
